FILE: rtl/assert_macros.svh
// Assertion macros shared by the edge magnitude RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define SEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be true outside reset.
`define SEM_NEVER(lbl, cond, msg) \
  `SEM_ASSERT(lbl, !(cond), msg)

`endif

FILE: rtl/sem_pkg.sv
// Types and constants shared by the Sobel edge magnitude block.
package sem_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } sem_in_t;

  typedef struct packed {
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic       frame_end;
  } sem_out_t;

  localparam logic       KIND_PIXEL   = 1'b0;
  localparam logic       KIND_FLUSH   = 1'b1;
  localparam logic [1:0] CFG_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT   = 2'd1;
  localparam int         CFG_IDX_W    = 2;
  localparam int         PIX_W        = 24;
  localparam int         ROW_W        = 13;
  localparam int         OROW_W       = 12;
  localparam logic [10:0] WIDTH_RST   = 11'd1024;
  localparam logic [12:0] HEIGHT_RST  = 13'd768;
  localparam logic [12:0] MAX_HEIGHT  = 13'd4096;
  // Above this sum of squares the rounded root exceeds 255.
  localparam logic [20:0] SAT_BOUND   = 21'd65280;
  localparam logic [7:0]  SAT_LIMIT   = 8'd255;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_SQUARE = 6'b000100,
    ST_START  = 6'b001000,
    ST_WAIT   = 6'b010000,
    ST_FIN    = 6'b100000
  } sem_state_e;

  // Channel 0 is red, 1 green, 2 blue.
  function automatic logic [7:0] chan(input logic [PIX_W-1:0] p, input logic [1:0] ch);
    logic [7:0] v;
    case (ch)
      2'd0:    v = p[23:16];
      2'd1:    v = p[15:8];
      default: v = p[7:0];
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/sobel_edge_magnitude_rgb_core.sv
// An item with a result passes the read, square, start, wait and finish states,
// finish held until the output is free; one with none goes back to idle after read.
// Each channel has its own eight-step bit-serial root unit; items enter only in idle.
// The line stores need no clearing; reset returns the state, frame size, counters,
// window, valid and last flags to their reset values, and the block is ready at once.
`include "assert_macros.svh"
module sobel_edge_magnitude_rgb_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  sem_pkg::sem_in_t                     in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output sem_pkg::sem_out_t                    out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sem_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [12:0]                          cfg_data_i
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int RW = sem_pkg::ROW_W;
  localparam int OW = sem_pkg::OROW_W;
  localparam int PW = sem_pkg::PIX_W;

  sem_pkg::sem_state_e state_q, state_d;

  logic [10:0]   fwidth_q, fwidth_d;
  logic [12:0]   fheight_q, fheight_d;
  logic [CW-1:0] in_col_q, in_col_d;
  logic [RW-1:0] in_row_q, in_row_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [OW-1:0] out_row_q, out_row_d;
  logic [PW-1:0] win_q [3][3];
  logic [PW-1:0] win_d [3][3];
  logic [CW-1:0] ic_q, ic_d;
  logic [RW-1:0] ir_q, ir_d;
  logic [PW-1:0] pix_q, pix_d;
  logic          last_q, last_d;
  logic signed [10:0] gx_q [3];
  logic signed [10:0] gy_q [3];
  logic signed [10:0] gx_d [3];
  logic signed [10:0] gy_d [3];
  logic [20:0]   sq_q [3];
  logic [20:0]   sq_d [3];
  sem_pkg::sem_out_t out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;
  logic [CW-1:0] cur_ic;
  logic [WW-1:0] nic;
  logic          in_acc, cfg_acc, emit;
  logic [PW-1:0] top_rd, mid_rd;
  logic          ram_we;
  logic [2:0]    root_done;
  logic [7:0]    root_val [3];
  logic          root_start;
  logic [7:0]    mv [3][3];
  logic          m_top, m_bot, m_lft, m_rgt;
  logic signed [21:0] px2, py2;

  // Effective frame size after clamping.
  always_comb begin
    if (fwidth_q == 11'd0) begin
      w_eff = WW'(1);
    end else if (WW'(fwidth_q) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fwidth_q);
    end
    if (fheight_q == 13'd0) begin
      h_eff = 13'd1;
    end else if (fheight_q > sem_pkg::MAX_HEIGHT) begin
      h_eff = sem_pkg::MAX_HEIGHT;
    end else begin
      h_eff = fheight_q;
    end
  end

  assign cur_ic      = (WW'(in_col_q) >= w_eff) ? '0 : in_col_q;
  assign cfg_ready_o = (state_q == sem_pkg::ST_IDLE);
  assign in_ready_o  = (state_q == sem_pkg::ST_IDLE) && !cfg_valid_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign ram_we      = (state_q == sem_pkg::ST_READ);
  assign root_start  = (state_q == sem_pkg::ST_START);
  assign emit        = (ir_q >= RW'(2)) || ((ir_q == RW'(1)) && (ic_q != '0));
  assign nic         = WW'(ic_q) + WW'(1);

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_row_above (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ic_q),
    .wdata_i (pix_q),
    .raddr_i (cur_ic),
    .rdata_o (mid_rd)
  );

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_row_two_above (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ic_q),
    .wdata_i (mid_rd),
    .raddr_i (cur_ic),
    .rdata_o (top_rd)
  );

  // Window shift, neighbour masking and Sobel sums.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = top_rd;
    win_d[1][2] = mid_rd;
    win_d[2][2] = pix_q;
    m_top = (out_row_q == '0);
    m_bot = (RW'(out_row_q) + RW'(1) >= h_eff);
    m_lft = (out_col_q == '0);
    m_rgt = (WW'(out_col_q) + WW'(1) >= w_eff);
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mv[r][c] = sem_pkg::chan(win_d[r][c], 2'(ch));
          if ((r == 0 && m_top) || (r == 2 && m_bot) || (c == 0 && m_lft) ||
              (c == 2 && m_rgt)) begin
            mv[r][c] = 8'd0;
          end
        end
      end
      gx_d[ch] = $signed({3'b000, mv[0][2]}) + $signed({2'b00, mv[1][2], 1'b0})
               + $signed({3'b000, mv[2][2]}) - $signed({3'b000, mv[0][0]})
               - $signed({2'b00, mv[1][0], 1'b0}) - $signed({3'b000, mv[2][0]});
      gy_d[ch] = $signed({3'b000, mv[2][0]}) + $signed({2'b00, mv[2][1], 1'b0})
               + $signed({3'b000, mv[2][2]}) - $signed({3'b000, mv[0][0]})
               - $signed({2'b00, mv[0][1], 1'b0}) - $signed({3'b000, mv[0][2]});
    end
  end

  always_comb begin
    px2 = '0;
    py2 = '0;
    for (int ch = 0; ch < 3; ch++) begin
      px2 = 22'(gx_q[ch] * gx_q[ch]);
      py2 = 22'(gy_q[ch] * gy_q[ch]);
      sq_d[ch] = px2[20:0] + py2[20:0];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_root
    sem_root u_root (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (root_start),
      .x_i     (sq_q[g]),
      .done_o  (root_done[g]),
      .root_o  (root_val[g])
    );
  end

  // Sequencer and frame bookkeeping.
  always_comb begin
    state_d     = state_q;
    fwidth_d    = fwidth_q;
    fheight_d   = fheight_q;
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    ic_d        = ic_q;
    ir_d        = ir_q;
    pix_d       = pix_q;
    last_d      = last_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      sem_pkg::ST_IDLE: begin
        if (cfg_acc) begin
          if (cfg_index_i == sem_pkg::CFG_WIDTH) begin
            fwidth_d = cfg_data_i[10:0];
          end
          if (cfg_index_i == sem_pkg::CFG_HEIGHT) begin
            fheight_d = cfg_data_i;
          end
          if (cfg_index_i == sem_pkg::CFG_WIDTH || cfg_index_i == sem_pkg::CFG_HEIGHT) begin
            in_col_d  = '0;
            in_row_d  = '0;
            out_col_d = '0;
            out_row_d = '0;
          end
        end else if (in_acc) begin
          ic_d = cur_ic;
          ir_d = in_row_q;
          if (in_data_i.kind == sem_pkg::KIND_PIXEL && in_row_q < h_eff) begin
            pix_d = {in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue};
          end else begin
            pix_d = '0;
          end
          state_d = sem_pkg::ST_READ;
        end
      end
      sem_pkg::ST_READ: begin
        last_d = 1'b0;
        if (nic >= w_eff) begin
          in_col_d = '0;
          in_row_d = ir_q + RW'(1);
        end else begin
          in_col_d = nic[CW-1:0];
          in_row_d = ir_q;
        end
        if (emit) begin
          last_d = (RW'(out_row_q) == h_eff - 13'd1) &&
                   (WW'(out_col_q) == w_eff - WW'(1));
          if (WW'(out_col_q) + WW'(1) >= w_eff) begin
            out_col_d = '0;
            out_row_d = out_row_q + OW'(1);
          end else begin
            out_col_d = out_col_q + CW'(1);
          end
          if (last_d) begin
            in_col_d  = '0;
            in_row_d  = '0;
            out_col_d = '0;
            out_row_d = '0;
          end
          state_d = sem_pkg::ST_SQUARE;
        end else begin
          state_d = sem_pkg::ST_IDLE;
        end
      end
      sem_pkg::ST_SQUARE: state_d = sem_pkg::ST_START;
      sem_pkg::ST_START:  state_d = sem_pkg::ST_WAIT;
      sem_pkg::ST_WAIT: begin
        if (root_done[0]) begin
          state_d = sem_pkg::ST_FIN;
        end
      end
      sem_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.edge_red   = root_val[0];
          out_d.edge_green = root_val[1];
          out_d.edge_blue  = root_val[2];
          out_d.frame_end  = last_q;
          out_valid_d      = 1'b1;
          state_d          = sem_pkg::ST_IDLE;
        end
      end
      default: state_d = sem_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sem_pkg::ST_IDLE;
      fwidth_q    <= sem_pkg::WIDTH_RST;
      fheight_q   <= sem_pkg::HEIGHT_RST;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      state_q     <= state_d;
      fwidth_q    <= fwidth_d;
      fheight_q   <= fheight_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      // A width or height write or the end of a frame empties the window.
      if ((cfg_acc && (cfg_index_i == sem_pkg::CFG_WIDTH ||
                       cfg_index_i == sem_pkg::CFG_HEIGHT)) ||
          (state_q == sem_pkg::ST_READ && last_d)) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            win_q[r][c] <= '0;
          end
        end
      end else if (state_q == sem_pkg::ST_READ) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ic_q  <= ic_d;
    ir_q  <= ir_d;
    pix_q <= pix_d;
    out_q <= out_d;
    if (state_q == sem_pkg::ST_READ) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
    if (state_q == sem_pkg::ST_SQUARE) begin
      sq_q <= sq_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SEM_ASSERT(a_acc_to_read, in_acc |=> (state_q == sem_pkg::ST_READ), "item not read")
  `SEM_NEVER(a_cfg_and_item, cfg_acc && in_acc, "item and register write together")
  `SEM_ASSERT(a_lanes_agree, root_done == {3{root_done[0]}}, "root lanes out of step")
  `SEM_ASSERT(a_fin_wait, $rose(state_q == sem_pkg::ST_FIN) |-> $past(root_done[0]), "early fin")
endmodule

FILE: rtl/sem_ram.sv
// Generic single write port, single read port RAM with registered read.
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/sem_root.sv
// Rounded, saturated square root resolved one result bit per cycle.
module sem_root (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [20:0] x_i,
  output logic        done_o,
  output logic [7:0]  root_o
);
  logic [15:0] x_q, x_d;
  logic [10:0] rem_q, rem_d;
  logic [7:0]  q_q, q_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        sat_q, sat_d;
  logic [10:0] trial;
  logic [10:0] cand;

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sat_d  = sat_q;
    cand   = {rem_q[8:0], x_q[15:14]};
    trial  = {1'b0, q_q, 2'b01};
    if (start_i) begin
      x_d    = x_i[15:0];
      sat_d  = x_i > sem_pkg::SAT_BOUND;
      rem_d  = '0;
      q_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d = {x_q[13:0], 2'b00};
      if (cand >= trial) begin
        rem_d = cand - trial;
        q_d   = {q_q[6:0], 1'b1};
      end else begin
        rem_d = cand;
        q_d   = {q_q[6:0], 1'b0};
      end
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    rem_q <= rem_d;
    q_q   <= q_d;
    sat_q <= sat_d;
  end

  // The remainder x - q*q exceeds q exactly when the root rounds up.
  assign done_o = busy_q && (cnt_q == 3'd7);
  assign root_o = sat_q ? sem_pkg::SAT_LIMIT :
                  ((rem_q > {3'b000, q_q}) ? q_q + 8'd1 : q_q);
endmodule
